// ===== rtl/rsl_pkg.sv =====
// Shared types, constants and a helper function of the radial spotlight luma block.
package rsl_pkg;

    localparam int CFG_W  = 12;
    localparam int LUMA_W = 16;
    localparam int SQ_W   = 16;
    localparam int ROOT_W = 8;
    localparam int SQRT_STAGES = 4;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx REG_CENTER_X = 1'b0;
    localparam t_cfg_idx REG_CENTER_Y = 1'b1;

    localparam int DIST_CAP_SQ = 25600;
    localparam logic [ROOT_W-1:0] DIST_CAP  = 8'd160;
    localparam logic [ROOT_W-1:0] SCALE_DEN = 8'd200;

    // x / 200 == (x >> 3) / 25; the /25 is a multiply by ceil(2^32 / 25), exact for x < 2^24
    localparam int PROD_W  = LUMA_W + ROOT_W;
    localparam int QIN_W   = PROD_W - 3;
    localparam int RECIP_W = 28;
    localparam logic [RECIP_W-1:0] RECIP25 = 28'd171798692;
    localparam int RECIP_SHIFT = 32;
    localparam int QPROD_W = QIN_W + RECIP_W;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } t_sqrt;

    // One digit of the restoring square root
    function automatic t_sqrt sqrt_step(t_sqrt s, logic [SQ_W-1:0] b);
        t_sqrt       o;
        logic [SQ_W:0] trial;
        trial = {1'b0, s.root} + {1'b0, b};
        if ({1'b0, s.rem} >= trial) begin
            o.rem  = s.rem - trial[SQ_W-1:0];
            o.root = (s.root >> 1) + b;
        end else begin
            o.rem  = s.rem;
            o.root = s.root >> 1;
        end
        return o;
    endfunction

endpackage

// ===== rtl/radial_spotlight_luma.sv =====
// Throughput: one item per cycle while not stalled; ten register stages (3 distance, 4 square root, 3 scale).
// The whole pipeline advances together; it holds only while a result waits under i_stall.
// Reset (synchronous, active low) clears all stage valid bits and both centre registers.
// Configuration writes are always taken (o_cfg_ready is tied high).
module radial_spotlight_luma #(
    parameter int COORD_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [COORD_BITS-1:0]      i_pix_x,
    input  logic [COORD_BITS-1:0]      i_pix_y,
    input  logic [rsl_pkg::LUMA_W-1:0] i_luma_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [rsl_pkg::LUMA_W-1:0] o_luma_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  rsl_pkg::t_cfg_idx          i_cfg_index,
    input  logic [rsl_pkg::CFG_W-1:0]  i_cfg_data
);
    import rsl_pkg::*;

    localparam int CEXT_W = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;

    logic [CFG_W-1:0]      r_center_x, r_center_y;
    logic [CEXT_W-1:0]     cen_x_ext, cen_y_ext;
    logic                  en;
    logic                  d_vld, d_clamp, q_vld;
    logic [SQ_W-1:0]       d_sq;
    logic [LUMA_W-1:0]     d_luma, q_luma;
    logic [ROOT_W-1:0]     q_dist;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CENTER_X: r_center_x <= i_cfg_data;
                REG_CENTER_Y: r_center_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // centre is taken modulo 2^COORD_BITS
    assign cen_x_ext = CEXT_W'(r_center_x);
    assign cen_y_ext = CEXT_W'(r_center_y);

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    rsl_dist #(.COORD_BITS(COORD_BITS)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_pix_x (i_pix_x),
        .i_pix_y (i_pix_y),
        .i_cen_x (cen_x_ext[COORD_BITS-1:0]),
        .i_cen_y (cen_y_ext[COORD_BITS-1:0]),
        .i_luma  (i_luma_in),
        .o_vld   (d_vld),
        .o_clamp (d_clamp),
        .o_sq    (d_sq),
        .o_luma  (d_luma)
    );

    rsl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d_vld),
        .i_clamp (d_clamp),
        .i_sq    (d_sq),
        .i_luma  (d_luma),
        .o_vld   (q_vld),
        .o_dist  (q_dist),
        .o_luma  (q_luma)
    );

    rsl_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (q_vld),
        .i_dist  (q_dist),
        .i_luma  (q_luma),
        .o_vld   (o_valid),
        .o_luma  (o_luma_out)
    );

endmodule

// ===== rtl/rsl_dist.sv =====
// Distance front end: absolute differences, squares, sum and clamp detect (3 stages).
module rsl_dist #(
    parameter int COORD_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [COORD_BITS-1:0]      i_pix_x,
    input  logic [COORD_BITS-1:0]      i_pix_y,
    input  logic [COORD_BITS-1:0]      i_cen_x,
    input  logic [COORD_BITS-1:0]      i_cen_y,
    input  logic [rsl_pkg::LUMA_W-1:0] i_luma,
    output logic                       o_vld,
    output logic                       o_clamp,
    output logic [rsl_pkg::SQ_W-1:0]   o_sq,
    output logic [rsl_pkg::LUMA_W-1:0] o_luma
);
    import rsl_pkg::*;

    localparam int SQ2_W = 2 * COORD_BITS;
    localparam int SUM_W = SQ2_W + 1;
    localparam int CMP_W = (SUM_W > SQ_W) ? SUM_W : SQ_W;

    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [SQ2_W-1:0]      r_sqx, r_sqy;
    logic [2:0]            r_vld;
    logic [LUMA_W-1:0]     r_luma1, r_luma2, r_luma3;
    logic                  r_clamp;
    logic [SQ_W-1:0]       r_sq;
    logic [CMP_W-1:0]      n_sum;

    assign n_sum = CMP_W'(r_sqx) + CMP_W'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx    <= (i_pix_x >= i_cen_x) ? i_pix_x - i_cen_x : i_cen_x - i_pix_x;
            r_dy    <= (i_pix_y >= i_cen_y) ? i_pix_y - i_cen_y : i_cen_y - i_pix_y;
            r_luma1 <= i_luma;
            r_sqx   <= SQ2_W'(r_dx) * SQ2_W'(r_dx);
            r_sqy   <= SQ2_W'(r_dy) * SQ2_W'(r_dy);
            r_luma2 <= r_luma1;
            // below the cap the sum fits in 15 bits
            r_clamp <= (n_sum >= CMP_W'(DIST_CAP_SQ));
            r_sq    <= n_sum[SQ_W-1:0];
            r_luma3 <= r_luma2;
        end
    end

    assign o_vld   = r_vld[2];
    assign o_clamp = r_clamp;
    assign o_sq    = r_sq;
    assign o_luma  = r_luma3;

endmodule

// ===== rtl/rsl_sqrt.sv =====
// Pipelined integer square root, two digits per stage.
module rsl_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic                       i_clamp,
    input  logic [rsl_pkg::SQ_W-1:0]   i_sq,
    input  logic [rsl_pkg::LUMA_W-1:0] i_luma,
    output logic                       o_vld,
    output logic [rsl_pkg::ROOT_W-1:0] o_dist,
    output logic [rsl_pkg::LUMA_W-1:0] o_luma
);
    import rsl_pkg::*;

    t_sqrt             r_st    [SQRT_STAGES];
    logic              r_vld   [SQRT_STAGES];
    logic              r_clamp [SQRT_STAGES];
    logic [LUMA_W-1:0] r_luma  [SQRT_STAGES];

    genvar s;
    generate
        for (s = 0; s < SQRT_STAGES; s++) begin : g_stg
            t_sqrt             in_st;
            t_sqrt             n_st;
            logic              in_vld;
            logic              in_clamp;
            logic [LUMA_W-1:0] in_luma;

            if (s == 0) begin : g_first
                assign in_st    = '{rem: i_sq, root: '0};
                assign in_vld   = i_vld;
                assign in_clamp = i_clamp;
                assign in_luma  = i_luma;
            end else begin : g_next
                assign in_st    = r_st[s-1];
                assign in_vld   = r_vld[s-1];
                assign in_clamp = r_clamp[s-1];
                assign in_luma  = r_luma[s-1];
            end

            always_comb begin
                n_st = in_st;
                for (int j = 0; j < 2; j++) begin
                    n_st = sqrt_step(n_st, SQ_W'(1) << (SQ_W - 2 - 4 * s - 2 * j));
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s] <= in_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[s]    <= n_st;
                    r_clamp[s] <= in_clamp;
                    r_luma[s]  <= in_luma;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[SQRT_STAGES-1];
    assign o_dist = r_clamp[SQRT_STAGES-1] ? DIST_CAP : r_st[SQRT_STAGES-1].root[ROOT_W-1:0];
    assign o_luma = r_luma[SQRT_STAGES-1];

endmodule

// ===== rtl/rsl_scale.sv =====
// Luma scaling by (200 - d) / 200 and output register.
module rsl_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [rsl_pkg::ROOT_W-1:0] i_dist,
    input  logic [rsl_pkg::LUMA_W-1:0] i_luma,
    output logic                       o_vld,
    output logic [rsl_pkg::LUMA_W-1:0] o_luma
);
    import rsl_pkg::*;

    logic [2:0]         r_vld;
    logic [PROD_W-1:0]  r_prod;
    logic [QPROD_W-1:0] r_qprod;
    logic [LUMA_W-1:0]  r_luma_out;
    logic [ROOT_W-1:0]  n_factor;

    assign n_factor = SCALE_DEN - i_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod     <= PROD_W'(i_luma) * PROD_W'(n_factor);
            r_qprod    <= QPROD_W'(r_prod[PROD_W-1:3]) * QPROD_W'(RECIP25);
            r_luma_out <= r_qprod[RECIP_SHIFT +: LUMA_W];
        end
    end

    assign o_vld  = r_vld[2];
    assign o_luma = r_luma_out;

endmodule

// ===== rtl/rsl_checker.sv =====
// Port-level checker for the radial spotlight luma block, bound to the top level.
module rsl_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic [COORD_BITS-1:0]      i_pix_x,
    input logic [COORD_BITS-1:0]      i_pix_y,
    input logic [rsl_pkg::LUMA_W-1:0] i_luma_in,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [rsl_pkg::LUMA_W-1:0] o_luma_out,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input rsl_pkg::t_cfg_idx          i_cfg_index,
    input logic [rsl_pkg::CFG_W-1:0]  i_cfg_data
);
    // input side holds off only while a finished result is stuck at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without an output stall");

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_luma_out)))
        else $error("stalled result dropped or changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write not taken");

endmodule

bind radial_spotlight_luma rsl_checker #(.COORD_BITS(COORD_BITS)) u_rsl_checker (.*);
